/* rtl/ssb_demodulator_chain_macros.svh */
// Assertion macros shared by the demodulator chain modules.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SSB_DEMODULATOR_CHAIN_MACROS_SVH
`define SSB_DEMODULATOR_CHAIN_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define SSBD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssbd assertion failed");
// Next-cycle implication check.
`define SSBD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssbd assertion failed");
`else
`define SSBD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SSBD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/ssbd_pkg.sv */
// Package for the SSB demodulator chain: sizes, codes, shared types and the
// oscillator sine table. No dependencies.
package ssbd_pkg;

   localparam int TAPS             = 256;
   localparam int TAP_W            = $clog2(TAPS);
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_ADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int DIV_N_W          = 48;
   localparam int DIV_D_W          = 32;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [31:0] ENV_FLOOR   = 32'd17;
   localparam logic [47:0] GAIN_MIN    = 48'd167772;
   localparam logic [47:0] GAIN_MAX    = 48'd1677721600;
   localparam logic [31:0] GAIN_ONE    = 32'd16777216;

   // Input operation codes.
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_LOAD   = 1'b1
   } op_type;

   // Control register indexes.
   typedef enum logic [3:0] {
      CSR_PHASE_INC  = 4'd0,
      CSR_INPUT_RATE = 4'd1,
      CSR_OUTPUT_RATE = 4'd2,
      CSR_AGC_ENABLE = 4'd3,
      CSR_AGC_TARGET = 4'd4,
      CSR_ENV_ALPHA  = 4'd5,
      CSR_ATTACK     = 4'd6,
      CSR_DECAY      = 4'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_MIX,
      F_DIV_GO,
      F_DIV_WAIT,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_PUSH,
      B_FIR,
      B_DRAIN,
      B_ROUND,
      B_ENV_MUL,
      B_ENV_ADD,
      B_DIV_GO,
      B_DIV_WAIT,
      B_GAIN_MUL,
      B_GAIN_ADD,
      B_AGC_MUL,
      B_AGC_SHIFT,
      B_OUT
   } back_state_type;

   // Control register file contents.
   typedef struct packed {
      logic [31:0] phase_increment;
      logic [23:0] input_rate;
      logic [23:0] output_rate;
      logic        agc_enable;
      logic [23:0] agc_target;
      logic [23:0] envelope_alpha;
      logic [23:0] attack_alpha;
      logic [23:0] decay_alpha;
   } cfg_type;

   // One queue entry: a coefficient load or a decimated sample.
   typedef struct packed {
      logic               load;
      logic [7:0]         tap_index;
      logic signed [17:0] tap_real;
      logic signed [17:0] tap_imag;
      logic signed [23:0] sample_re;
      logic signed [23:0] sample_im;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef logic signed [24:0] sine_table_type [SINE_TABLE_DEPTH];

   // Sine of a turn fraction in Q2.23, odd polynomial over one quadrant.
   function automatic logic signed [24:0] sine_of_turn(input logic [31:0] u);
      logic [63:0]        r;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        s;
      logic [63:0]        t;
      logic [63:0]        v;
      logic signed [24:0] res;
      r = 64'(u[29:0]);
      if (u[30]) begin
         r = Q30_ONE - r;
      end
      x = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      s = Q30_ONE;
      for (int k = 7; k >= 1; k--) begin
         t = ((x2 * s) >> 30) / 64'((2 * k) * (2 * k + 1));
         s = Q30_ONE - t;
      end
      v = (((x * s) >> 30) + 64'd64) >> 7;
      res = 25'(v);
      if (u[31]) begin
         res = -res;
      end
      return res;
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         tab[k] = sine_of_turn(32'(k) << (32 - SINE_ADDR_W));
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

/* rtl/ssb_demodulator_chain.sv */
// SSB demodulator chain. A sample request takes the front end through the
// table read, four products through one shared multiplier and the mix; when
// it completes a decimation period the front also runs the 48-step average
// divider and the queue push. Each decimated sample then takes the back end
// through one filter tap per cycle over 256 taps from the single read port
// of the history memory, with pop, history write, pipeline drain, rounding
// and output load, plus the AGC, most of it in the 48-step gain divider.
// With the AGC off the back end goes from rounding straight to output load.
// A four-entry queue between the halves lets the front keep taking requests
// while the back filters, so sustained throughput is bounded by the back
// end per decimated output.
module ssb_demodulator_chain (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic signed [23:0] req_real_part,
   input  logic signed [23:0] req_imag_part,
   input  logic [7:0]         req_tap_index,
   input  logic signed [17:0] req_tap_real,
   input  logic signed [17:0] req_tap_imag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_audio_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import ssbd_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         cfg_clear;
   logic         q_push;
   logic         q_pop;
   work_type     q_in_data;
   work_type     q_head;
   q_status_type q_status;

   assign csr_ready = 1'b1;

   // Control register writes.
   always_comb begin
      cfg_in = cfg_ff;
      cfg_clear = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_INC: cfg_in.phase_increment = csr_data;
            CSR_INPUT_RATE: begin
               if (csr_data[23:0] != 24'd0) begin
                  cfg_in.input_rate = csr_data[23:0];
                  cfg_clear = 1'b1;
               end
            end
            CSR_OUTPUT_RATE: cfg_in.output_rate = csr_data[23:0];
            CSR_AGC_ENABLE: cfg_in.agc_enable = csr_data[0];
            CSR_AGC_TARGET: cfg_in.agc_target = csr_data[23:0];
            CSR_ENV_ALPHA: cfg_in.envelope_alpha = csr_data[23:0];
            CSR_ATTACK: cfg_in.attack_alpha = csr_data[23:0];
            CSR_DECAY: cfg_in.decay_alpha = csr_data[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_increment <= 32'd0;
         cfg_ff.input_rate <= 24'd192000;
         cfg_ff.output_rate <= 24'd48000;
         cfg_ff.agc_enable <= 1'b1;
         cfg_ff.agc_target <= 24'd16777215;
         cfg_ff.envelope_alpha <= 24'd34946;
         cfg_ff.attack_alpha <= 24'd69606;
         cfg_ff.decay_alpha <= 24'd1398;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ssbd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cfg_clear     (cfg_clear),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_real_part (req_real_part),
      .req_imag_part (req_imag_part),
      .req_tap_index (req_tap_index),
      .req_tap_real  (req_tap_real),
      .req_tap_imag  (req_tap_imag),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_data        (q_in_data)
   );

   ssbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head_data (q_head),
      .status    (q_status)
   );

   ssbd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_status         (q_status),
      .q_data           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_audio_sample (rsp_audio_sample)
   );

endmodule

/* rtl/ssbd_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ssbd_pkg for the operand widths.
module ssbd_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ssbd_pkg::DIV_N_W-1:0] dividend,
   input  logic [ssbd_pkg::DIV_D_W-1:0] divisor,
   output logic                         done,
   output logic [ssbd_pkg::DIV_N_W-1:0] quotient
);
   import ssbd_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W-1:0] div_ff, div_in;
   logic [DIV_D_W:0]   trial;

   // One shift-and-subtract step per cycle.
   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      trial = {rem_ff, quo_ff[DIV_N_W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_D_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = DIV_D_W'(trial);
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_N_W - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/ssbd_queue.sv */
// Short first-in first-out queue of work entries between front and back.
// Depends on ssbd_pkg for the entry type and depth.
module ssbd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ssbd_pkg::work_type     push_data,
   input  logic                   pop,
   output ssbd_pkg::work_type     head_data,
   output ssbd_pkg::q_status_type status
);
   import ssbd_pkg::*;

   work_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_W-1:0]  wr_ff, wr_in;
   logic [QUEUE_ADDR_W-1:0]  rd_ff, rd_in;
   logic [QUEUE_ADDR_W:0]    fill_ff, fill_in;

   // Pointer and fill count update.
   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   assign head_data = entry_ff[rd_ff];
   assign status.full = (fill_ff == (QUEUE_ADDR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);

endmodule

/* rtl/ssbd_front.sv */
// Front end: accepts requests, mixes samples with the oscillator, runs the
// box decimator and queues loads and decimated samples. Uses ssbd_pkg.
`include "ssb_demodulator_chain_macros.svh"
module ssbd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  ssbd_pkg::cfg_type       cfg,
   input  logic                    cfg_clear,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic signed [23:0]      req_real_part,
   input  logic signed [23:0]      req_imag_part,
   input  logic [7:0]              req_tap_index,
   input  logic signed [17:0]      req_tap_real,
   input  logic signed [17:0]      req_tap_imag,
   input  ssbd_pkg::q_status_type  q_status,
   output logic                    q_push,
   output ssbd_pkg::work_type      q_data
);
   import ssbd_pkg::*;

   front_state_type         state_ff, state_in;
   logic [31:0]             phase_ff, phase_in;
   logic [24:0]             rate_ff, rate_in;
   logic signed [31:0]      sum_re_ff, sum_re_in;
   logic signed [31:0]      sum_im_ff, sum_im_in;
   logic [7:0]              count_ff, count_in;
   logic [2:0]              step_ff, step_in;
   logic signed [23:0]      re_ff, re_in;
   logic signed [23:0]      im_ff, im_in;
   logic signed [24:0]      sin_ff, sin_in;
   logic signed [24:0]      cos_ff, cos_in;
   logic signed [48:0]      prod_ff;
   logic signed [49:0]      mi_ff, mi_in;
   logic signed [49:0]      mq_ff, mq_in;
   logic                    neg_re_ff, neg_re_in;
   logic                    neg_im_ff, neg_im_in;

   logic                    accept;
   logic [SINE_ADDR_W-1:0]  sine_idx;
   logic signed [23:0]      mul_a;
   logic signed [24:0]      mul_b;
   logic signed [48:0]      mul_p;
   logic signed [49:0]      mi_rnd;
   logic signed [49:0]      mq_rnd;
   logic signed [23:0]      mix_re;
   logic signed [23:0]      mix_im;
   logic [24:0]             rate_sum;
   logic [24:0]             rate_sub;
   logic                    fire;
   logic [7:0]              avg_n;
   logic [31:0]             mag_re;
   logic [31:0]             mag_im;
   logic                    div_start;
   logic                    div_re_done;
   logic                    div_im_done;
   logic [DIV_N_W-1:0]      div_re_q;
   logic [DIV_N_W-1:0]      div_im_q;
   logic signed [24:0]      avg_re;
   logic signed [24:0]      avg_im;

   // Saturate a rounded mixer sum to 24 bits.
   function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
      logic signed [23:0] r;
      if (v > 50'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -50'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   // Shared mixer multiplier: re*cos, im*sin, im*cos, re*sin in turn.
   assign mul_a = (step_ff == 3'd0 || step_ff == 3'd3) ? re_ff : im_ff;
   assign mul_b = step_ff[0] ? sin_ff : cos_ff;
   assign mul_p = mul_a * mul_b;

   assign mi_rnd = (mi_ff + 50'sd4194304) >>> 23;
   assign mq_rnd = (mq_ff + 50'sd4194304) >>> 23;
   assign mix_re = sat24(mi_rnd);
   assign mix_im = sat24(mq_rnd);

   // Fractional-rate decimation test.
   assign rate_sum = rate_ff + {1'b0, cfg.output_rate};
   assign fire = (rate_sum >= {1'b0, cfg.input_rate});
   assign rate_sub = fire ? rate_sum - {1'b0, cfg.input_rate} : rate_sum;

   // Rounded average: magnitude plus half the count, divided by the count.
   assign avg_n = (count_ff == 8'd0) ? 8'd1 : count_ff;
   assign mag_re = (sum_re_ff[31] ? 32'(-sum_re_ff) : 32'(sum_re_ff)) + 32'(avg_n[7:1]);
   assign mag_im = (sum_im_ff[31] ? 32'(-sum_im_ff) : 32'(sum_im_ff)) + 32'(avg_n[7:1]);
   assign div_start = (state_ff == F_DIV_GO);
   assign avg_re = neg_re_ff ? -div_re_q[24:0] : div_re_q[24:0];
   assign avg_im = neg_im_ff ? -div_im_q[24:0] : div_im_q[24:0];

   assign sine_idx = phase_ff[31 -: SINE_ADDR_W];

   ssbd_divider u_div_re (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_N_W'(mag_re)),
      .divisor  (DIV_D_W'(avg_n)),
      .done     (div_re_done),
      .quotient (div_re_q)
   );

   ssbd_divider u_div_im (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_N_W'(mag_im)),
      .divisor  (DIV_D_W'(avg_n)),
      .done     (div_im_done),
      .quotient (div_im_q)
   );

   // Next state and datapath control.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      rate_in = rate_ff;
      sum_re_in = sum_re_ff;
      sum_im_in = sum_im_ff;
      count_in = count_ff;
      step_in = step_ff;
      re_in = re_ff;
      im_in = im_ff;
      sin_in = sin_ff;
      cos_in = cos_ff;
      mi_in = mi_ff;
      mq_in = mq_ff;
      neg_re_in = neg_re_ff;
      neg_im_in = neg_im_ff;
      q_push = 1'b0;
      req_stall = (state_ff != F_IDLE) || q_status.full;
      accept = req_valid && !req_stall;

      q_data.load = (state_ff == F_IDLE);
      q_data.tap_index = req_tap_index;
      q_data.tap_real = req_tap_real;
      q_data.tap_imag = req_tap_imag;
      q_data.sample_re = avg_re[23:0];
      q_data.sample_im = avg_im[23:0];

      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  q_push = 1'b1;
               end else begin
                  re_in = req_real_part;
                  im_in = req_imag_part;
                  sin_in = SINE_TABLE[sine_idx];
                  cos_in = SINE_TABLE[sine_idx + SINE_ADDR_W'(SINE_TABLE_DEPTH / 4)];
                  step_in = 3'd0;
                  state_in = F_MUL;
               end
            end
         end
         F_MUL: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: mi_in = 50'(prod_ff);
               3'd2: mi_in = mi_ff + 50'(prod_ff);
               3'd3: mq_in = 50'(prod_ff);
               3'd4: begin
                  mq_in = mq_ff - 50'(prod_ff);
                  state_in = F_MIX;
               end
               default: ;
            endcase
         end
         F_MIX: begin
            if (count_ff != 8'hFF) begin
               sum_re_in = sum_re_ff + 32'(mix_re);
               sum_im_in = sum_im_ff + 32'(mix_im);
               count_in = count_ff + 8'd1;
            end
            rate_in = (rate_sub >= {1'b0, cfg.input_rate}) ?
                      {1'b0, cfg.input_rate} - 25'd1 : rate_sub;
            phase_in = phase_ff + cfg.phase_increment;
            state_in = fire ? F_DIV_GO : F_IDLE;
         end
         F_DIV_GO: begin
            neg_re_in = sum_re_ff[31];
            neg_im_in = sum_im_ff[31];
            sum_re_in = '0;
            sum_im_in = '0;
            count_in = '0;
            state_in = F_DIV_WAIT;
         end
         F_DIV_WAIT: begin
            if (div_re_done) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_status.full) begin
               q_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase

      // A new input rate restarts the decimator.
      if (cfg_clear) begin
         rate_in = '0;
         sum_re_in = '0;
         sum_im_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         phase_ff <= '0;
         rate_ff <= '0;
         sum_re_ff <= '0;
         sum_im_ff <= '0;
         count_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rate_ff <= rate_in;
         sum_re_ff <= sum_re_in;
         sum_im_ff <= sum_im_in;
         count_ff <= count_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      re_ff <= re_in;
      im_ff <= im_in;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
      prod_ff <= mul_p;
      mi_ff <= mi_in;
      mq_ff <= mq_in;
      neg_re_ff <= neg_re_in;
      neg_im_ff <= neg_im_in;
   end

   `SSBD_ASSERT_IMP(a_front_push_room, clock, reset, q_push, !q_status.full)
   `SSBD_ASSERT_NXT(a_front_sample_mix, clock, reset, accept && req_operation == OP_SAMPLE, state_ff == F_MUL)
   `SSBD_ASSERT_IMP(a_front_div_lockstep, clock, reset, div_re_done, div_im_done)

endmodule

/* rtl/ssbd_back.sv */
// Back end: complex FIR over the history store, AGC and output register.
// Uses ssbd_pkg and ssbd_divider; takes work from the front queue.
`include "ssb_demodulator_chain_macros.svh"
module ssbd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ssbd_pkg::cfg_type       cfg,
   input  ssbd_pkg::q_status_type  q_status,
   input  ssbd_pkg::work_type      q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [15:0]      rsp_audio_sample
);
   import ssbd_pkg::*;

   back_state_type      state_ff, state_in;
   logic [TAP_W-1:0]    head_ff, head_in;
   logic [TAPS-1:0]     valid_ff, valid_in;
   logic [TAP_W-1:0]    cnt_ff, cnt_in;
   logic                s1_ff, s1_in;
   logic                s2_ff;
   logic signed [51:0]  acc_ff, acc_in;
   logic [31:0]         env_ff, env_in;
   logic [31:0]         gain_ff, gain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  rsp_sample_ff, rsp_sample_in;

   logic [47:0]         sample_ff, sample_in;
   logic [47:0]         hist_mem [TAPS];
   logic [35:0]         coef_mem [TAPS];
   logic [47:0]         hist_rd_ff;
   logic                hvld_rd_ff;
   logic [35:0]         coef_rd_ff;
   logic signed [41:0]  prod_re_ff;
   logic signed [41:0]  prod_im_ff;
   logic signed [31:0]  xr_ff, xr_in;
   logic signed [40:0]  xa_ff, xa_in;
   logic signed [66:0]  prod_ff, prod_in;
   logic [31:0]         desired_ff, desired_in;

   logic                coef_we;
   logic                hist_we;
   logic                out_load;
   logic                div_start;
   logic                div_done;
   logic [DIV_N_W-1:0]  div_q;
   logic [TAP_W-1:0]    fir_addr;
   logic signed [23:0]  h_re;
   logic signed [23:0]  h_im;
   logic signed [51:0]  x_rnd;
   logic [32:0]         x_mag;
   logic signed [33:0]  env_diff;
   logic signed [33:0]  gain_diff;
   logic [23:0]         gain_alpha;
   logic signed [67:0]  env_sum;
   logic signed [67:0]  gain_sum;
   logic signed [25:0]  x_clamp;
   logic signed [25:0]  y_rnd;

   assign fir_addr = head_ff + cnt_ff;
   assign h_re = hvld_rd_ff ? $signed(hist_rd_ff[47:24]) : 24'sd0;
   assign h_im = hvld_rd_ff ? $signed(hist_rd_ff[23:0]) : 24'sd0;

   assign x_rnd = (acc_ff + 52'sd32768) >>> 16;
   assign x_mag = xr_ff[31] ? 33'(-34'(xr_ff)) : 33'(xr_ff);
   assign env_diff = $signed({1'b0, x_mag}) - $signed({2'b00, env_ff});
   assign gain_diff = $signed({2'b00, desired_ff}) - $signed({2'b00, gain_ff});
   assign gain_alpha = (desired_ff < gain_ff) ? cfg.attack_alpha : cfg.decay_alpha;
   assign env_sum = $signed({36'd0, env_ff}) + 68'(prod_ff >>> 24);
   assign gain_sum = $signed({36'd0, gain_ff}) + 68'(prod_ff >>> 24);

   assign x_clamp = (xa_ff > 41'sd16777216) ? 26'sd16777216 :
                    (xa_ff < -41'sd16777216) ? -26'sd16777216 : xa_ff[25:0];
   assign y_rnd = (x_clamp + 26'sd256) >>> 9;

   assign div_start = (state_ff == B_DIV_GO);

   ssbd_divider u_div_gain (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({cfg.agc_target, 24'd0}),
      .divisor  ((env_ff > ENV_FLOOR) ? env_ff : ENV_FLOOR),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sequencer for one queue entry.
   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      valid_in = valid_ff;
      cnt_in = cnt_ff;
      s1_in = 1'b0;
      acc_in = acc_ff;
      env_in = env_ff;
      gain_in = gain_ff;
      sample_in = sample_ff;
      xr_in = xr_ff;
      xa_in = xa_ff;
      prod_in = prod_ff;
      desired_in = desired_ff;
      q_pop = 1'b0;
      coef_we = 1'b0;
      hist_we = 1'b0;
      out_load = 1'b0;

      if (s2_ff) begin
         acc_in = acc_ff + 52'(prod_re_ff) - 52'(prod_im_ff);
      end

      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               if (q_data.load) begin
                  coef_we = (int'(q_data.tap_index) < TAPS);
                  valid_in = '0;
                  head_in = '0;
               end else begin
                  head_in = head_ff - 1'b1;
                  sample_in = {q_data.sample_re, q_data.sample_im};
                  state_in = B_PUSH;
               end
            end
         end
         B_PUSH: begin
            hist_we = 1'b1;
            valid_in[head_ff] = 1'b1;
            cnt_in = '0;
            acc_in = '0;
            state_in = B_FIR;
         end
         B_FIR: begin
            s1_in = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == TAP_W'(TAPS - 1)) begin
               state_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = B_ROUND;
            end
         end
         B_ROUND: begin
            if (x_rnd > 52'sd2147483647) begin
               xr_in = 32'sh7FFFFFFF;
            end else if (x_rnd < -52'sd2147483648) begin
               xr_in = 32'sh80000000;
            end else begin
               xr_in = x_rnd[31:0];
            end
            if (cfg.agc_enable) begin
               state_in = B_ENV_MUL;
            end else begin
               gain_in = GAIN_ONE;
               xa_in = 41'(xr_in);
               state_in = B_OUT;
            end
         end
         B_ENV_MUL: begin
            prod_in = env_diff * $signed({1'b0, cfg.envelope_alpha});
            state_in = B_ENV_ADD;
         end
         B_ENV_ADD: begin
            if (env_sum < 68'sd0) begin
               env_in = '0;
            end else if (env_sum > 68'sd4294967295) begin
               env_in = 32'hFFFFFFFF;
            end else begin
               env_in = env_sum[31:0];
            end
            state_in = B_DIV_GO;
         end
         B_DIV_GO: begin
            state_in = B_DIV_WAIT;
         end
         B_DIV_WAIT: begin
            if (div_done) begin
               if (div_q < GAIN_MIN) begin
                  desired_in = GAIN_MIN[31:0];
               end else if (div_q > GAIN_MAX) begin
                  desired_in = GAIN_MAX[31:0];
               end else begin
                  desired_in = div_q[31:0];
               end
               state_in = B_GAIN_MUL;
            end
         end
         B_GAIN_MUL: begin
            prod_in = gain_diff * $signed({1'b0, gain_alpha});
            state_in = B_GAIN_ADD;
         end
         B_GAIN_ADD: begin
            if (gain_sum < 68'sd0) begin
               gain_in = '0;
            end else if (gain_sum > 68'sd4294967295) begin
               gain_in = 32'hFFFFFFFF;
            end else begin
               gain_in = gain_sum[31:0];
            end
            state_in = B_AGC_MUL;
         end
         B_AGC_MUL: begin
            prod_in = xr_ff * $signed({1'b0, gain_ff});
            state_in = B_AGC_SHIFT;
         end
         B_AGC_SHIFT: begin
            xa_in = 41'(prod_ff >>> 24);
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase

      // Output register.
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
      rsp_sample_in = rsp_sample_ff;
      if (out_load) begin
         if (y_rnd > 26'sd32767) begin
            rsp_sample_in = 16'sh7FFF;
         end else if (y_rnd < -26'sd32768) begin
            rsp_sample_in = 16'sh8000;
         end else begin
            rsp_sample_in = y_rnd[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         head_ff <= '0;
         valid_ff <= '0;
         cnt_ff <= '0;
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         acc_ff <= '0;
         env_ff <= '0;
         gain_ff <= GAIN_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         valid_ff <= valid_in;
         cnt_ff <= cnt_in;
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         acc_ff <= acc_in;
         env_ff <= env_in;
         gain_ff <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Tap pipeline: memory read, then the two lane products.
   always_ff @(posedge clock) begin
      hist_rd_ff <= hist_mem[fir_addr];
      hvld_rd_ff <= valid_ff[fir_addr];
      coef_rd_ff <= coef_mem[cnt_ff];
      prod_re_ff <= h_re * $signed(coef_rd_ff[35:18]);
      prod_im_ff <= h_im * $signed(coef_rd_ff[17:0]);
      sample_ff <= sample_in;
      xr_ff <= xr_in;
      xa_ff <= xa_in;
      prod_ff <= prod_in;
      desired_ff <= desired_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // History and coefficient stores.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[head_ff] <= sample_ff;
      end
      if (coef_we) begin
         coef_mem[TAP_W'(q_data.tap_index)] <= {q_data.tap_real, q_data.tap_imag};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_audio_sample = rsp_sample_ff;

   `SSBD_ASSERT_IMP(a_back_pop_nonempty, clock, reset, q_pop, !q_status.empty)
   `SSBD_ASSERT_IMP(a_back_out_room, clock, reset, out_load, !rsp_valid_ff || !rsp_stall)
   `SSBD_ASSERT_IMP(a_back_idle_drained, clock, reset, state_ff == B_IDLE, !s1_ff && !s2_ff)

endmodule

/* tb/ssbd_audio_checker.sv */
// Checker for the SSB demodulator chain: watches the request, result and register
// channels, predicts each audio sample and compares it. Depends on ssbd_pkg.
module ssbd_audio_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_operation,
   input  logic signed [23:0] req_real_part,
   input  logic signed [23:0] req_imag_part,
   input  logic [7:0]         req_tap_index,
   input  logic signed [17:0] req_tap_real,
   input  logic signed [17:0] req_tap_imag,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_audio_sample,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ssbd_pkg::*;

   localparam longint unsigned TURN_Q30 = 64'd1073741824;
   localparam longint unsigned QUARTER_PI_X2 = 64'd1686629713;
   localparam longint UNITY_GAIN = 64'd16777216;

   int          sine_lut [SINE_TABLE_DEPTH];
   logic [31:0] phase_step, osc_phase;
   longint      in_rate, out_rate, target_level, env_alpha, attack_a, decay_a;
   logic        agc_on;
   longint      rate_acc, sum_re, sum_im, envelope, gain;
   int          avg_count, hist_head;
   int          hist_re [TAPS];
   int          hist_im [TAPS];
   int          coef_re [TAPS];
   int          coef_im [TAPS];
   shortint     audio_expected [$];
   shortint     oldest;

   assign pending = audio_expected.size();

   // Sine of a turn fraction in Q2.23 from a series over one quadrant.
   function automatic int sine_at_turn(logic [31:0] u);
      longint unsigned r, x, x2, s, t, v;
      r = 64'(u[29:0]);
      if (u[30]) begin
         r = TURN_Q30 - r;
      end
      x = (r * QUARTER_PI_X2) >> 30;
      x2 = (x * x) >> 30;
      s = TURN_Q30;
      for (int k = 7; k >= 1; k--) begin
         t = ((x2 * s) >> 30) / 64'((2 * k) * (2 * k + 1));
         s = TURN_Q30 - t;
      end
      v = (((x * s) >> 30) + 64'd64) >> 7;
      return u[31] ? -int'(v) : int'(v);
   endfunction

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Division rounded half away from zero.
   function automatic longint div_round(longint v, longint n);
      if (v >= 0) begin
         return (v + n / 2) / n;
      end
      return -((-v + n / 2) / n);
   endfunction

   task automatic clear_history();
      for (int k = 0; k < TAPS; k++) begin
         hist_re[k] = 0;
         hist_im[k] = 0;
      end
      hist_head = 0;
   endtask

   task automatic reset_state();
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         sine_lut[k] = sine_at_turn(32'(k) << (32 - SINE_ADDR_W));
      end
      phase_step = 0;
      in_rate = 192000;
      out_rate = 48000;
      agc_on = 1'b1;
      target_level = 16777215;
      env_alpha = 34946;
      attack_a = 69606;
      decay_a = 1398;
      osc_phase = 0;
      rate_acc = 0;
      sum_re = 0;
      sum_im = 0;
      avg_count = 0;
      clear_history();
      for (int k = 0; k < TAPS; k++) begin
         coef_re[k] = 0;
         coef_im[k] = 0;
      end
      envelope = 0;
      gain = UNITY_GAIN;
      audio_expected.delete();
      errors = 0;
   endtask

   task automatic write_register(logic [3:0] idx, logic [31:0] data);
      case (csr_index_type'(idx))
         CSR_PHASE_INC: phase_step = data;
         CSR_INPUT_RATE: begin
            // A zero modulus is refused; any other value restarts the decimator.
            if (data[23:0] != 0) begin
               in_rate = data[23:0];
               rate_acc = 0;
               sum_re = 0;
               sum_im = 0;
               avg_count = 0;
            end
         end
         CSR_OUTPUT_RATE: out_rate = data[23:0];
         CSR_AGC_ENABLE: agc_on = data[0];
         CSR_AGC_TARGET: target_level = data[23:0];
         CSR_ENV_ALPHA: env_alpha = data[23:0];
         CSR_ATTACK: attack_a = data[23:0];
         CSR_DECAY: decay_a = data[23:0];
         default: ;
      endcase
   endtask

   // Mix, decimate, filter and level one request; queue the audio it yields.
   task automatic demodulate_request();
      longint i, q, c, s, mi, mq, acc, x, want, alpha, n;
      int k, j;
      logic fire;
      if (req_operation == OP_LOAD) begin
         coef_re[req_tap_index] = req_tap_real;
         coef_im[req_tap_index] = req_tap_imag;
         clear_history();
         return;
      end
      i = req_real_part;
      q = req_imag_part;
      k = osc_phase[31:32 - SINE_ADDR_W];
      s = sine_lut[k];
      c = sine_lut[(k + SINE_TABLE_DEPTH / 4) % SINE_TABLE_DEPTH];
      mi = sat((i * c + q * s + (64'sd1 << 22)) >>> 23, -8388608, 8388607);
      mq = sat((q * c - i * s + (64'sd1 << 22)) >>> 23, -8388608, 8388607);
      // The average stops growing once the count is full.
      if (avg_count < 255) begin
         sum_re += mi;
         sum_im += mq;
         avg_count++;
      end
      rate_acc += out_rate;
      fire = rate_acc >= in_rate;
      if (fire) begin
         rate_acc -= in_rate;
      end
      if (rate_acc >= in_rate) begin
         rate_acc = in_rate - 1;
      end
      osc_phase += phase_step;
      if (!fire) begin
         return;
      end
      n = avg_count != 0 ? avg_count : 1;
      hist_head = (hist_head + TAPS - 1) % TAPS;
      hist_re[hist_head] = int'(div_round(sum_re, n));
      hist_im[hist_head] = int'(div_round(sum_im, n));
      sum_re = 0;
      sum_im = 0;
      avg_count = 0;
      // Complex FIR, real part only.
      acc = 0;
      for (k = 0; k < TAPS; k++) begin
         j = (hist_head + k) % TAPS;
         acc += longint'(hist_re[j]) * coef_re[k] - longint'(hist_im[j]) * coef_im[k];
      end
      x = sat((acc + (64'sd1 << 15)) >>> 16, -64'sd2147483648, 64'sd2147483647);
      if (agc_on) begin
         envelope += (env_alpha * ((x < 0 ? -x : x) - envelope)) >>> 24;
         envelope = sat(envelope, 0, 64'sd4294967295);
         want = (target_level << 24) / (envelope > 17 ? envelope : 17);
         want = sat(want, 167772, 1677721600);
         alpha = want < gain ? attack_a : decay_a;
         gain += (alpha * (want - gain)) >>> 24;
         gain = sat(gain, 0, 64'sd4294967295);
         x = (x * gain) >>> 24;
      end else begin
         gain = UNITY_GAIN;
      end
      x = sat(x, -UNITY_GAIN, UNITY_GAIN);
      audio_expected.push_back(shortint'(sat((x + 256) >>> 9, -32768, 32767)));
   endtask

   // Results are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         reset_state();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (audio_expected.size() == 0) begin
               $display("%0t: audio sample %0d arrived with none expected",
                        $time, rsp_audio_sample);
               errors++;
            end else begin
               oldest = audio_expected.pop_front();
               if (oldest != rsp_audio_sample) begin
                  $display("%0t: audio_sample expected %0d actual %0d",
                           $time, oldest, rsp_audio_sample);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            write_register(csr_index, csr_data);
         end
         if (req_valid && !req_stall) begin
            demodulate_request();
         end
      end
   end

endmodule

/* tb/testbench.sv */
// Top of the SSB demodulator chain testbench: clock, reset, stimulus, flow
// control and verdict. Depends on ssbd_pkg, ssbd_audio_checker and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ssbd_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 400;
   localparam int HOLD_CYCLES = 3000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = OP_SAMPLE;
   logic signed [23:0] req_real_part = '0;
   logic signed [23:0] req_imag_part = '0;
   logic [7:0]         req_tap_index = '0;
   logic signed [17:0] req_tap_real = '0;
   logic signed [17:0] req_tap_imag = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_audio_sample;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;
   int                 errors;
   int                 pending;
   int                 burst_left = 8;
   int                 idle_cycles = 0;
   bit                 hold_request = 0;

   ssb_demodulator_chain dut (.*);
   ssbd_audio_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Any accepted transfer resets the watchdog.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stall patterns in segments, plus an occasional long hold-off.
   initial begin
      int seg_len, stall_pct;
      forever begin
         seg_len = $urandom_range(20, 200);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 90;
         endcase
         repeat (seg_len) begin
            @(posedge clock);
            if (hold_request) begin
               hold_request = 0;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            rsp_stall <= $urandom_range(1, 100) <= stall_pct;
         end
      end
   end

   // Offer one request and hold it until accepted; then maybe end the burst.
   task automatic send_request(logic op, logic [23:0] re, logic [23:0] im,
                               logic [7:0] idx, logic [17:0] tr, logic [17:0] ti);
      int gap;
      req_valid <= 1'b1;
      req_operation <= op;
      req_real_part <= re;
      req_imag_part <= im;
      req_tap_index <= idx;
      req_tap_real <= tr;
      req_tap_imag <= ti;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 30);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_sample(logic [23:0] re, logic [23:0] im);
      send_request(OP_SAMPLE, re, im, 8'($urandom), 18'($urandom), 18'($urandom));
   endtask

   task automatic send_load(logic [7:0] idx, logic [17:0] tr, logic [17:0] ti);
      send_request(OP_LOAD, 24'($urandom), 24'($urandom), idx, tr, ti);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic end_csr_writes();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending and wait until every audio sample is back and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] pick_alpha();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom);
         default: return 24'($urandom_range(1, 200000));
      endcase
   endfunction

   // Write every register with a random setting that favors extremes now and then.
   task automatic random_settings();
      int in_r, out_r;
      case ($urandom_range(0, 9))
         0: begin
            in_r = 24'hFFFFFF;
            out_r = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'hFFFFFF / 3;
         end
         1: begin
            in_r = $urandom_range(1, 5000);
            out_r = in_r + $urandom_range(1, 5000);
         end
         default: begin
            in_r = $urandom_range(1000, 200000);
            out_r = in_r / $urandom_range(1, 8);
         end
      endcase
      case ($urandom_range(0, 4))
         0: write_csr(CSR_PHASE_INC, 32'h8000_0000);
         1: write_csr(CSR_PHASE_INC, 32'h7FFF_FFFF);
         2: write_csr(CSR_PHASE_INC, 32'h0);
         default: write_csr(CSR_PHASE_INC, $urandom);
      endcase
      write_csr(CSR_INPUT_RATE, in_r);
      write_csr(CSR_OUTPUT_RATE, out_r);
      write_csr(CSR_AGC_ENABLE, $urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: write_csr(CSR_AGC_TARGET, 0);
         1: write_csr(CSR_AGC_TARGET, 24'hFFFFFF);
         default: write_csr(CSR_AGC_TARGET, $urandom);
      endcase
      write_csr(CSR_ENV_ALPHA, 32'(pick_alpha()));
      write_csr(CSR_ATTACK, 32'(pick_alpha()));
      write_csr(CSR_DECAY, 32'(pick_alpha()));
      end_csr_writes();
   endtask

   // Mostly full-range samples, some extremes and a few coefficient loads.
   task automatic random_requests(int count);
      repeat (count) begin
         case ($urandom_range(0, 19))
            0: send_load(8'($urandom), 18'($urandom), 18'($urandom));
            1: send_sample(($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000,
                           ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000);
            default: send_sample(24'($urandom), 24'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole coefficient store first, mostly with moderate taps.
      for (int k = 0; k < TAPS; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_load(8'(k), 18'($urandom), 18'($urandom));
         end else begin
            send_load(8'(k), 18'(int'($urandom_range(0, 4000)) - 2000),
                      18'(int'($urandom_range(0, 4000)) - 2000));
         end
      end

      // Directed requests at reset settings: sample extremes and load extremes.
      send_sample(24'h7FFFFF, 24'h7FFFFF);
      send_sample(24'h800000, 24'h800000);
      send_sample(24'h7FFFFF, 24'h800000);
      send_sample(24'h800000, 24'h7FFFFF);
      send_sample(24'h0, 24'h0);
      send_sample(24'h000001, 24'hFFFFFF);
      send_sample(24'hFFFFFF, 24'h000001);
      send_sample(24'h555555, 24'hAAAAAA);
      send_load(8'd0, 18'h1FFFF, 18'h20000);
      send_load(8'd255, 18'h20000, 18'h1FFFF);
      for (int k = 0; k < 12; k++) begin
         send_sample(24'h7FFFFF, 24'h0);
      end
      drain();

      // Rejected zero input rate, output rate zero: no audio at all.
      write_csr(CSR_INPUT_RATE, 0);
      write_csr(CSR_OUTPUT_RATE, 0);
      end_csr_writes();
      random_requests(30);
      drain();

      // Long decimation so the averaging count saturates.
      write_csr(CSR_INPUT_RATE, 300);
      write_csr(CSR_OUTPUT_RATE, 1);
      write_csr(CSR_AGC_ENABLE, 0);
      end_csr_writes();
      for (int k = 0; k < 610; k++) begin
         send_sample(24'($urandom), 24'($urandom));
      end
      drain();

      // Output faster than input with the receiver held off: the block backs up.
      write_csr(CSR_INPUT_RATE, 1000);
      write_csr(CSR_OUTPUT_RATE, 5000);
      end_csr_writes();
      hold_request = 1;
      random_requests(60);
      drain();

      // Random settings phases.
      repeat (8) begin
         random_settings();
         random_requests($urandom_range(50, 80));
         drain();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
